/* rtl/gtl_pkg.sv */
// ============================================================================
// gtl_pkg - shared types and constants for the global-to-local index remap
// Extent packing, register indexes, status codes and pipeline beat types.
// ============================================================================
package gtl_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int EXTENT_BITS = 8;
    localparam int POS_W       = 32;
    localparam int REG_W       = 32;
    localparam int DC_W        = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_R       = 4;              // quotient bits per divider stage
    localparam int DIV_STAGES  = POS_W / DIV_R;
    localparam int SIZE_W      = POS_W + 1;      // mesh size saturates at 2^POS_W

    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(1) << POS_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_COUNT      = 2'd0,
        CFG_GLOBAL_EXTENTS = 2'd1,
        CFG_LOCAL_EXTENTS  = 2'd2,
        CFG_LOCAL_ORIGIN   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_INSIDE  = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_BEYOND  = 2'd2,
        ST_BAD_BOX = 2'd3
    } t_status;

    typedef logic [EXTENT_BITS-1:0]              t_ext;
    typedef logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] t_ext_arr;

    // Slot 0 is outermost; unused outer slots padded with extent 1, origin 0
    typedef struct packed {
        t_ext_arr g;
        t_ext_arr l;
        t_ext_arr o;
    } t_dims;

    typedef struct packed {
        logic             bad;
        logic [POS_W-1:0] pos;
    } t_item;

    typedef struct packed {
        logic             vld;
        logic             bad;
        logic [POS_W-1:0] pos;
        t_ext_arr         rm;
    } t_tag;

    typedef struct packed {
        logic             vld;
        logic             bad;
        logic             beyond;
        logic             outside;
        t_ext_arr         rm;
        logic [POS_W-1:0] c0;
        logic [POS_W-1:0] loc;
    } t_hor;

    function automatic t_dims dims_of(input logic [DC_W-1:0] dc,
                                      input logic [REG_W-1:0] ge,
                                      input logic [REG_W-1:0] le,
                                      input logic [REG_W-1:0] lo);
        t_dims r;
        int    n;
        int    sh;
        n = int'(dc);
        if (n == 0) n = 1;
        if (n > MAX_DIMS) n = MAX_DIMS;
        for (int s = 0; s < MAX_DIMS; s++) begin
            sh = (MAX_DIMS - 1 - s) * EXTENT_BITS;
            if (s < MAX_DIMS - n) begin
                r.g[s] = t_ext'(1);
                r.l[s] = t_ext'(1);
                r.o[s] = '0;
            end else begin
                r.g[s] = t_ext'(ge >> sh);
                r.l[s] = t_ext'(le >> sh);
                r.o[s] = t_ext'(lo >> sh);
            end
        end
        return r;
    endfunction

endpackage

/* rtl/gtl_div.sv */
// ============================================================================
// gtl_div - pipelined restoring divider, position by one extent
// DIV_R quotient bits per stage; sideband beat travels alongside.
// ============================================================================
module gtl_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  gtl_pkg::t_tag            i_tag,
    input  logic [gtl_pkg::POS_W-1:0] i_num,
    input  gtl_pkg::t_ext            i_den,
    output gtl_pkg::t_tag            o_tag,
    output logic [gtl_pkg::POS_W-1:0] o_quo,
    output gtl_pkg::t_ext            o_rem
);

    gtl_pkg::t_tag             w_tag [0:gtl_pkg::DIV_STAGES];
    logic [gtl_pkg::POS_W-1:0] w_num [0:gtl_pkg::DIV_STAGES];
    gtl_pkg::t_ext             w_rem [0:gtl_pkg::DIV_STAGES];
    gtl_pkg::t_ext             w_den [0:gtl_pkg::DIV_STAGES];

    assign w_tag[0] = i_tag;
    assign w_num[0] = i_num;
    assign w_rem[0] = '0;
    assign w_den[0] = i_den;

    for (genvar k = 0; k < gtl_pkg::DIV_STAGES; k++) begin : g_stg
        gtl_pkg::t_tag             r_tag;
        logic [gtl_pkg::POS_W-1:0] r_num, n_num;
        gtl_pkg::t_ext             r_rem, n_rem;
        gtl_pkg::t_ext             r_den;

        always_comb begin : p_step
            logic [gtl_pkg::EXTENT_BITS:0]   wide;
            gtl_pkg::t_ext                   rem;
            logic [gtl_pkg::POS_W-1:0]       num;
            rem = w_rem[k];
            num = w_num[k];
            for (int b = 0; b < gtl_pkg::DIV_R; b++) begin
                wide = {rem, num[gtl_pkg::POS_W-1-(k*gtl_pkg::DIV_R+b)]};
                if (wide >= {1'b0, w_den[k]}) begin
                    wide = wide - {1'b0, w_den[k]};
                    num[gtl_pkg::POS_W-1-(k*gtl_pkg::DIV_R+b)] = 1'b1;
                end else begin
                    num[gtl_pkg::POS_W-1-(k*gtl_pkg::DIV_R+b)] = 1'b0;
                end
                rem = wide[gtl_pkg::EXTENT_BITS-1:0];
            end
            n_num = num;
            n_rem = rem;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag.vld <= 1'b0;
            end else begin
                r_tag <= w_tag[k];
            end
            r_num <= n_num;
            r_rem <= n_rem;
            r_den <= w_den[k];
        end

        assign w_tag[k+1] = r_tag;
        assign w_num[k+1] = r_num;
        assign w_rem[k+1] = r_rem;
        assign w_den[k+1] = r_den;
    end

    assign o_tag = w_tag[gtl_pkg::DIV_STAGES];
    assign o_quo = w_num[gtl_pkg::DIV_STAGES];
    assign o_rem = w_rem[gtl_pkg::DIV_STAGES];

endmodule

/* rtl/gtl_front.sv */
// ============================================================================
// gtl_front - accepts positions, flags a bad box, queues beats
// Also keeps the saturating mesh size up to date from the configuration.
// ============================================================================
module gtl_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gtl_pkg::POS_W-1:0] i_pos,
    input  gtl_pkg::t_dims            i_dims,
    output logic                      o_busy,
    output logic                      o_vld,
    output gtl_pkg::t_item            o_item,
    output logic [gtl_pkg::SIZE_W-1:0] o_size
);

    gtl_pkg::t_item r_q [0:1];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt, n_cnt;
    logic           push, pop, bad;

    // box must fit the mesh in every slot
    always_comb begin
        bad = 1'b0;
        for (int s = 0; s < gtl_pkg::MAX_DIMS; s++) begin
            if (({1'b0, i_dims.o[s]} + {1'b0, i_dims.l[s]}) > {1'b0, i_dims.g[s]}) begin
                bad = 1'b1;
            end
        end
    end

    assign o_busy = (r_cnt == 2'd2);
    assign push   = i_start && !o_busy;
    assign pop    = (r_cnt != 2'd0);      // back end takes a beat every cycle
    assign o_vld  = pop;
    assign o_item = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
        end
        if (push) begin
            r_q[r_wp] <= '{bad: bad, pos: i_pos};
        end
    end

    // mesh size, one extent per register
    logic [gtl_pkg::SIZE_W-1:0] w_size [0:gtl_pkg::MAX_DIMS];
    assign w_size[0] = gtl_pkg::SIZE_W'(1);

    for (genvar s = 0; s < gtl_pkg::MAX_DIMS; s++) begin : g_size
        logic [gtl_pkg::SIZE_W-1:0]                      r_size, n_size;
        logic [gtl_pkg::SIZE_W+gtl_pkg::EXTENT_BITS-1:0] prod;

        always_comb begin
            prod = (gtl_pkg::SIZE_W+gtl_pkg::EXTENT_BITS)'(w_size[s])
                 * (gtl_pkg::SIZE_W+gtl_pkg::EXTENT_BITS)'(i_dims.g[s]);
            if (prod > (gtl_pkg::SIZE_W+gtl_pkg::EXTENT_BITS)'(gtl_pkg::SIZE_CAP)) begin
                n_size = gtl_pkg::SIZE_CAP;
            end else begin
                n_size = prod[gtl_pkg::SIZE_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_size <= n_size;
        end

        assign w_size[s+1] = r_size;
    end

    assign o_size = w_size[gtl_pkg::MAX_DIMS];

endmodule

/* rtl/gtl_back.sv */
// ============================================================================
// gtl_back - splits position into coordinates and builds the local index
// Divider chain innermost first, then one Horner step per dimension.
// ============================================================================
module gtl_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  gtl_pkg::t_item             i_item,
    input  gtl_pkg::t_dims             i_dims,
    input  logic [gtl_pkg::SIZE_W-1:0] i_size,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [gtl_pkg::POS_W-1:0]  o_local
);

    gtl_pkg::t_tag             c_tag [0:gtl_pkg::MAX_DIMS-1];
    logic [gtl_pkg::POS_W-1:0] c_num [0:gtl_pkg::MAX_DIMS-1];

    assign c_tag[0] = '{vld: i_vld, bad: i_item.bad, pos: i_item.pos, rm: '0};
    assign c_num[0] = i_item.pos;

    // divider j peels slot MAX_DIMS-1-j
    for (genvar j = 0; j < gtl_pkg::MAX_DIMS - 1; j++) begin : g_div
        gtl_pkg::t_tag             d_tag;
        logic [gtl_pkg::POS_W-1:0] d_quo;
        gtl_pkg::t_ext             d_rem;

        gtl_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (c_tag[j]),
            .i_num   (c_num[j]),
            .i_den   (i_dims.g[gtl_pkg::MAX_DIMS-1-j]),
            .o_tag   (d_tag),
            .o_quo   (d_quo),
            .o_rem   (d_rem)
        );

        always_comb begin
            c_tag[j+1] = d_tag;
            c_tag[j+1].rm[gtl_pkg::MAX_DIMS-1-j] = d_rem;
        end
        assign c_num[j+1] = d_quo;
    end

    gtl_pkg::t_hor h [0:gtl_pkg::MAX_DIMS];

    assign h[0] = '{vld:     c_tag[gtl_pkg::MAX_DIMS-1].vld,
                    bad:     c_tag[gtl_pkg::MAX_DIMS-1].bad,
                    beyond:  ({1'b0, c_tag[gtl_pkg::MAX_DIMS-1].pos} >= i_size),
                    outside: 1'b0,
                    rm:      c_tag[gtl_pkg::MAX_DIMS-1].rm,
                    c0:      c_num[gtl_pkg::MAX_DIMS-1],
                    loc:     '0};

    for (genvar s = 0; s < gtl_pkg::MAX_DIMS; s++) begin : g_hor
        gtl_pkg::t_hor r_hor, n_hor;

        always_comb begin : p_hor
            logic [gtl_pkg::POS_W-1:0] crd;
            logic [gtl_pkg::POS_W-1:0] org;
            logic [gtl_pkg::POS_W:0]   hi;
            crd = (s == 0) ? h[s].c0 : gtl_pkg::POS_W'(h[s].rm[s]);
            org = gtl_pkg::POS_W'(i_dims.o[s]);
            hi  = (gtl_pkg::POS_W+1)'(i_dims.o[s]) + (gtl_pkg::POS_W+1)'(i_dims.l[s]);
            n_hor         = h[s];
            n_hor.outside = h[s].outside || (crd < org) || ({1'b0, crd} >= hi);
            n_hor.loc     = h[s].loc * gtl_pkg::POS_W'(i_dims.l[s]) + (crd - org);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hor.vld <= 1'b0;
            end else begin
                r_hor <= n_hor;
            end
        end

        assign h[s+1] = r_hor;
    end

    logic                      r_done;
    logic [1:0]                r_status;
    logic [gtl_pkg::POS_W-1:0] r_local;
    gtl_pkg::t_status          st;

    always_comb begin
        if (h[gtl_pkg::MAX_DIMS].bad) begin
            st = gtl_pkg::ST_BAD_BOX;
        end else if (h[gtl_pkg::MAX_DIMS].beyond) begin
            st = gtl_pkg::ST_BEYOND;
        end else if (h[gtl_pkg::MAX_DIMS].outside) begin
            st = gtl_pkg::ST_OUTSIDE;
        end else begin
            st = gtl_pkg::ST_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= h[gtl_pkg::MAX_DIMS].vld;
        end
        r_status <= st;
        r_local  <= (st == gtl_pkg::ST_INSIDE) ? h[gtl_pkg::MAX_DIMS].loc : '0;
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_local  = r_local;

endmodule

/* rtl/global_to_local_shard_index_unit.sv */
// ============================================================================
// global_to_local_shard_index_unit - global row-major index to local box index
// Path from start to o_done: queue register, divider stages, Horner steps, output register.
// Throughput: one position per cycle; set by the pipelined extent dividers.
// The receiver cannot stall; the back end drains the queue every cycle, so o_busy
// never rises.
// Reset (sync, active low) clears the pipeline and loads the register defaults.
// ============================================================================
module global_to_local_shard_index_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command side
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [gtl_pkg::POS_W-1:0]     i_global_position,
    // result side
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic [gtl_pkg::POS_W-1:0]     o_local_position,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [gtl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gtl_pkg::REG_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [gtl_pkg::DC_W-1:0]  r_dim_count;
    logic [gtl_pkg::REG_W-1:0] r_global_extents;
    logic [gtl_pkg::REG_W-1:0] r_local_extents;
    logic [gtl_pkg::REG_W-1:0] r_local_origin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count      <= gtl_pkg::DC_W'(1);
            r_global_extents <= gtl_pkg::REG_W'(1);
            r_local_extents  <= gtl_pkg::REG_W'(1);
            r_local_origin   <= '0;
        end else if (i_cfg_we) begin
            case (gtl_pkg::t_cfg_idx'(i_cfg_idx))
                gtl_pkg::CFG_DIM_COUNT:      r_dim_count      <= i_cfg_data[gtl_pkg::DC_W-1:0];
                gtl_pkg::CFG_GLOBAL_EXTENTS: r_global_extents <= i_cfg_data;
                gtl_pkg::CFG_LOCAL_EXTENTS:  r_local_extents  <= i_cfg_data;
                gtl_pkg::CFG_LOCAL_ORIGIN:   r_local_origin   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // unpacked per-slot extents; unused outer slots look like a 1-wide dimension,
    // which keeps the datapath uniform whatever the dimension count
    gtl_pkg::t_dims dims;
    assign dims = gtl_pkg::dims_of(r_dim_count, r_global_extents,
                                   r_local_extents, r_local_origin);

    logic                       q_vld;
    gtl_pkg::t_item             q_item;
    logic [gtl_pkg::SIZE_W-1:0] size;

    // front: accept, bad-box flag, short queue, mesh size
    gtl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_pos   (i_global_position),
        .i_dims  (dims),
        .o_busy  (o_busy),
        .o_vld   (q_vld),
        .o_item  (q_item),
        .o_size  (size)
    );

    // back: coordinate split, box test, local index
    gtl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (q_vld),
        .i_item   (q_item),
        .i_dims   (dims),
        .i_size   (size),
        .o_done   (o_done),
        .o_status (o_status),
        .o_local  (o_local_position)
    );

endmodule

/* tb/sv/tb_top.sv */
// ============================================================================
// tb_top - testbench for the global-to-local shard index unit
// Drives global positions through the command port under several box and mesh
// settings, predicts status and local index per beat and checks every result.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gtl_pkg::*;

    localparam int LATENCY = 30;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 o_busy;
    logic [POS_W-1:0]     i_global_position = '0;
    logic                 o_done;
    logic [1:0]           o_status;
    logic [POS_W-1:0]     o_local_position;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [REG_W-1:0]     i_cfg_data = '0;

    always #1 i_clk = ~i_clk;

    global_to_local_shard_index_unit dut (.*);

    // Shadow copy of the configuration registers
    logic [DC_W-1:0]  sh_dims;
    logic [REG_W-1:0] sh_gext, sh_lext, sh_orig;

    typedef struct {
        t_status          status;
        logic [POS_W-1:0] loc;
    } t_remap;

    t_remap remap_q[$];
    int     errors   = 0;
    int     results  = 0;
    int     beats    = 0;
    int     send_gap = 0;   // sender idle percentage

    // Predicts one remap from the shadow registers
    function automatic t_remap remap_of(input logic [POS_W-1:0] pos);
        t_remap r;
        int n;
        longint unsigned g[MAX_DIMS], l[MAX_DIMS], o[MAX_DIMS], c[MAX_DIMS];
        longint unsigned mesh, rest, idx, sh;
        n = (sh_dims == 0) ? 1 : (sh_dims > MAX_DIMS) ? MAX_DIMS : int'(sh_dims);
        r.status = ST_INSIDE;
        r.loc    = '0;
        for (int d = 0; d < n; d++) begin
            sh = (n - 1 - d) * EXTENT_BITS;
            g[d] = 64'((sh_gext >> sh) & 32'hFF);
            l[d] = 64'((sh_lext >> sh) & 32'hFF);
            o[d] = 64'((sh_orig >> sh) & 32'hFF);
        end
        for (int d = 0; d < n; d++)
            if (o[d] + l[d] > g[d]) begin
                r.status = ST_BAD_BOX;
                return r;
            end
        mesh = 1;
        for (int d = 0; d < n; d++) begin
            mesh = mesh * g[d];
            if (mesh > 64'h1_0000_0000) mesh = 64'h1_0000_0000;
        end
        if (64'(pos) >= mesh) begin
            r.status = ST_BEYOND;
            return r;
        end
        rest = 64'(pos);
        for (int d = n - 1; d > 0; d--) begin
            c[d] = rest % g[d];
            rest = rest / g[d];
        end
        c[0] = rest;
        idx = 0;
        for (int d = 0; d < n; d++) begin
            if (c[d] < o[d] || c[d] >= o[d] + l[d]) begin
                r.status = ST_OUTSIDE;
                return r;
            end
            idx = idx * l[d] + (c[d] - o[d]);
        end
        r.loc = idx[POS_W-1:0];
        return r;
    endfunction

    // Writes one register; only called with the pipeline drained
    task automatic write_reg(input t_cfg_idx idx, input logic [REG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_DIM_COUNT:      sh_dims = val[DC_W-1:0];
            CFG_GLOBAL_EXTENTS: sh_gext = val;
            CFG_LOCAL_EXTENTS:  sh_lext = val;
            default:            sh_orig = val;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_box(input logic [DC_W-1:0] n, input logic [REG_W-1:0] ge,
                           input logic [REG_W-1:0] le, input logic [REG_W-1:0] lo);
        write_reg(CFG_DIM_COUNT, REG_W'(n));
        write_reg(CFG_GLOBAL_EXTENTS, ge);
        write_reg(CFG_LOCAL_EXTENTS, le);
        write_reg(CFG_LOCAL_ORIGIN, lo);
    endtask

    // Sends one beat; start stays high across back-to-back beats
    task automatic send_pos(input logic [POS_W-1:0] pos);
        logic acc;
        while ($urandom_range(99, 0) < send_gap) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start           <= 1'b1;
        i_global_position <= pos;
        do begin
            @(negedge i_clk);
            acc = !o_busy;
            @(posedge i_clk);
        end while (!acc);
        remap_q.push_back(remap_of(pos));
        beats++;
    endtask

    // Waits for every expected result, then the pipeline depth again
    task automatic drain;
        i_start <= 1'b0;
        while (remap_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Result checker; o_done is a one-cycle strobe
    always @(posedge i_clk) begin
        t_remap want;
        if (i_rst_n && o_done) begin
            results++;
            if (remap_q.size() == 0) begin
                $display("%0t unexpected result status=%0d loc=%0h",
                         $time, o_status, o_local_position);
                errors++;
            end else begin
                want = remap_q.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, want.status, o_status);
                    errors++;
                end
                if (o_local_position !== want.loc) begin
                    $display("%0t local position mismatch: expected %0h actual %0h",
                             $time, want.loc, o_local_position);
                    errors++;
                end
            end
        end
    end

    // Random position biased towards the mesh, with some far beyond it
    function automatic logic [POS_W-1:0] rand_pos;
        longint unsigned mesh;
        int n;
        n = (sh_dims == 0) ? 1 : (sh_dims > MAX_DIMS) ? MAX_DIMS : int'(sh_dims);
        mesh = 1;
        for (int d = 0; d < n; d++) mesh = mesh * ((sh_gext >> (d * 8)) & 8'hFF);
        if (mesh == 0 || $urandom_range(9, 0) == 0) return $urandom;
        if (mesh > 64'hFFFF_FFFF) return $urandom;
        return POS_W'($urandom_range(32'(mesh + 2), 0));
    endfunction

    // Directed: reset defaults, extremes, all status codes, odd dim counts
    task automatic test_directed;
        send_pos('0);
        send_pos(1);
        send_pos('1);
        drain();
        set_box(3'd2, 32'h0000_0405, 32'h0000_0203, 32'h0000_0101);
        for (int p = 0; p < 8; p++) send_pos(p * 3);
        send_pos(19);
        send_pos(20);
        drain();
        set_box(3'd4, 32'hFFFF_FFFF, 32'hFF01_FF01, 32'h00FE_00FE);
        send_pos('1);
        send_pos(32'h00FE_00FE);
        send_pos(32'hFFFE_00FE);
        drain();
        set_box(3'd0, 32'hAB00_0010, 32'h0000_000F, 32'h0000_0002); // zero -> one dim
        send_pos(2); send_pos(16); send_pos(1);
        drain();
        set_box(3'd7, 32'h0203_0000, 32'h0101_0000, 32'h0);         // zero global extent
        send_pos(0);
        drain();
        set_box(3'd3, 32'h0004_0404, 32'h0002_0002, 32'h0003_0102); // bad box
        send_pos(0);
        drain();
        set_box(3'd2, 32'h0000_0808, 32'h0000_0800, 32'h0);         // empty box
        send_pos(5);
        drain();
    endtask

    // Random settings with random positions
    task automatic test_random(input int count);
        logic [REG_W-1:0] ge, le, lo;
        logic [DC_W-1:0]  n;
        int done_here;
        done_here = 0;
        while (done_here < count) begin
            n  = DC_W'($urandom_range(7, 0));
            ge = $urandom;
            if ($urandom_range(3, 0) != 0)
                for (int d = 0; d < 4; d++) ge[d*8 +: 8] = 8'($urandom_range(12, 1));
            le = '0;
            lo = '0;
            for (int d = 0; d < 4; d++) begin
                lo[d*8 +: 8] = 8'($urandom_range(ge[d*8 +: 8], 0));
                le[d*8 +: 8] = 8'($urandom_range(ge[d*8 +: 8] - lo[d*8 +: 8], 0));
            end
            if ($urandom_range(9, 0) == 0) le = $urandom;   // mostly a bad box
            set_box(n, ge, le, lo);
            for (int i = 0; i < 70; i++) send_pos(rand_pos());
            done_here += 70;
            drain();
        end
    endtask

    initial begin
        sh_dims = 1; sh_gext = 1; sh_lext = 1; sh_orig = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_gap = 36;
        test_random(560);
        send_gap = 87;
        test_random(560);
        send_gap = 0;
        test_random(560);
        drain();
        $display("Covered %0d beats and %0d results over all status codes,",
                 beats, results);
        $display("dim counts 0..7 and extents up to 255.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
